>>> rtl/core/dpd_pkg.sv
// Package for the window-average defective pixel detector.
// Sizes, register map, reset values and shared types; no dependencies.
`default_nettype none

package dpd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_WIDTH  = 5;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LW_W   = 11;
  localparam int OUT_W  = 10;
  localparam int IDX_W  = 20;

  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int WIN       = 5;
  localparam int NUM_BANKS = 4;
  localparam int SLOT_W    = $clog2(NUM_BANKS);

  localparam int RSUM_W = 11;
  localparam int SUM_W  = 13;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CH_W-1:0] THRESHOLD_RST  = 8'd25;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd1024;

  typedef enum logic [1:0] {
    REG_WINDOW_MODE = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_LINE_WIDTH  = 2'd2
  } dpd_reg_e;

  typedef struct packed {
    logic             elig;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [IDX_W-1:0] index;
  } dpd_pos_t;

  typedef logic [WIN-1:0][WIN-1:0][CH_W-1:0] dpd_chwin_t;

endpackage

`default_nettype wire

>>> rtl/core/dpd_line_store.sv
// Line store: four banks of one image line each, read at one column per word.
// Depends on dpd_pkg.
`default_nettype none

module dpd_line_store import dpd_pkg::*; (
  input  logic                             clk_i,
  input  logic                             acc_i,
  input  logic [SLOT_W-1:0]                wr_slot_i,
  input  logic [COL_W-1:0]                 col_i,
  input  logic [PIX_W-1:0]                 pixel_i,
  output logic [NUM_BANKS-1:0][PIX_W-1:0]  rd_data_o
);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_q;

    // read-before-write on the bank holding the oldest line
    always_ff @(posedge clk_i) begin
      if (acc_i) begin
        rd_q <= mem[col_i];
        if (wr_slot_i == SLOT_W'(b)) begin
          mem[col_i] <= pixel_i;
        end
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

`default_nettype wire

>>> rtl/core/dpd_window.sv
// 5x5 window registers, shifted left by one column per word.
// Depends on dpd_pkg; fed by dpd_line_store.
`default_nettype none

module dpd_window import dpd_pkg::*; (
  input  logic                             clk_i,
  input  logic                             shift_i,
  input  logic [PIX_W-1:0]                 pixel_i,
  input  logic [SLOT_W-1:0]                row_slot_i,
  input  logic [NUM_BANKS-1:0][PIX_W-1:0]  rd_data_i,
  output dpd_chwin_t [NUM_CH-1:0]          win_o
);

  logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_q, win_d;
  logic [WIN-1:0][PIX_W-1:0]          column;

  always_comb begin
    column[WIN-1] = pixel_i;
    for (int k = 1; k < WIN; k++) begin
      column[WIN-1-k] = rd_data_i[SLOT_W'(row_slot_i - SLOT_W'(k))];
    end
  end

  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN-1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
      win_d[r][WIN-1] = column[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          win_o[ch][r][c] = win_q[r][c][ch*CH_W +: CH_W];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dpd_lane.sv
// One channel lane: masked neighbour sum against N times centre, two stages.
// Depends on dpd_pkg.
`default_nettype none

module dpd_lane import dpd_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            mode_i,
  input  logic [CH_W-1:0] threshold_i,
  input  dpd_chwin_t      win_i,
  output logic            flag_o
);

  logic [WIN-1:0][RSUM_W-1:0] rsum_d, rsum_q;
  logic [CH_W-1:0]            centre_d, centre_q;
  logic [SUM_W-1:0]           total, scaled, limit, diff;
  logic                       flag_d, flag_q;

  // stage A: per-row sums, centre excluded
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      rsum_d[r] = '0;
      for (int c = 0; c < WIN; c++) begin
        if (mode_i) begin
          if (!(r == 2 && c == 2)) rsum_d[r] = rsum_d[r] + RSUM_W'(win_i[r][c]);
        end else begin
          if (r >= 2 && c >= 2 && !(r == 3 && c == 3)) begin
            rsum_d[r] = rsum_d[r] + RSUM_W'(win_i[r][c]);
          end
        end
      end
    end
    centre_d = mode_i ? win_i[2][2] : win_i[3][3];
  end

  // stage B: |sum - N*centre| > N*threshold
  always_comb begin
    total = '0;
    for (int r = 0; r < WIN; r++) begin
      total = total + SUM_W'(rsum_q[r]);
    end
    if (mode_i) begin
      scaled = (SUM_W'(centre_q) << 4) + (SUM_W'(centre_q) << 3);
      limit  = (SUM_W'(threshold_i) << 4) + (SUM_W'(threshold_i) << 3);
    end else begin
      scaled = SUM_W'(centre_q) << 3;
      limit  = SUM_W'(threshold_i) << 3;
    end
    diff   = (total >= scaled) ? (total - scaled) : (scaled - total);
    flag_d = diff > limit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsum_q   <= rsum_d;
      centre_q <= centre_d;
      flag_q   <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

`default_nettype wire

>>> rtl/core/dpd_merge.sv
// Merge stage: ORs the lane flags and holds the result word for the receiver.
// Depends on dpd_pkg.
`default_nettype none

module dpd_merge import dpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  dpd_pos_t          pos_i,
  input  logic [NUM_CH-1:0] flags_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [OUT_W-1:0]  defect_row_o,
  output logic [OUT_W-1:0]  defect_col_o,
  output logic [IDX_W-1:0]  defect_index_o,
  output logic              stall_o
);

  logic             hit, load;
  logic             out_valid_d, out_valid_q;
  logic [OUT_W-1:0] row_q, col_q;
  logic [IDX_W-1:0] index_q;

  assign hit     = valid_i && pos_i.elig && (|flags_i);
  assign stall_o = hit && out_valid_q && !out_ready_i;
  assign load    = hit && !stall_o;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q   <= OUT_W'(pos_i.row);
      col_q   <= OUT_W'(pos_i.col);
      index_q <= pos_i.index;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign defect_row_o   = row_q;
  assign defect_col_o   = col_q;
  assign defect_index_o = index_q;

endmodule

`default_nettype wire

>>> rtl/core/window_average_defect_pixel_detect.sv
// Defective pixel detector, neighbour average over a 3x3 or 5x5 window.
// Top level; depends on dpd_pkg, dpd_line_store, dpd_window, dpd_lane, dpd_merge.
//
// Input channel (in_valid_i/in_ready_o) takes one four-channel pixel word per
// cycle in raster order; last_pixel_i ends the frame and restarts the row and
// column counters. Output channel (out_valid_o/out_ready_i) carries one word
// per defective centre: row, column and linear index, in raster order.
// Registers over the APB port: 0 window mode, 1 threshold, 2 line width;
// write them only while no word is in flight.
// Throughput: one pixel per cycle while in_ready_o is high. The path from the
// pixel that completes a window to its defect on the output runs line-store
// read, window shift, row sums, compare, result register.
// Four channel lanes judge in parallel and the merge stage ORs their flags.
// When the result register is full and the receiver stalls, the pipeline
// holds only if another defect reaches the merge stage; otherwise pixels
// keep flowing. Reset clears the counters, pipeline valids and registers
// (mode 0, threshold 25, width 1024); line store and window are not cleared.
`default_nettype none

module window_average_defect_pixel_detect import dpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               last_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OUT_W-1:0]   defect_row_o,
  output logic [OUT_W-1:0]   defect_col_o,
  output logic [IDX_W-1:0]   defect_index_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic                 mode_q;
  logic [CH_W-1:0]      threshold_q;
  logic [LW_W-1:0]      line_width_q;
  logic                 cfg_wr;
  logic [LW_W-1:0]      eff_w;

  logic                 adv, acc, stall;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [COL_W:0]       col_inc;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [PIX_W-1:0]     px1_q;
  logic [ROW_W-1:0]     row1_q;
  logic [COL_W-1:0]     col1_q;
  dpd_pos_t             pos2_d, pos2_q, pos3_d, pos3_q, pos4_q;
  logic [ROW_W+LW_W-1:0] prod;

  logic [NUM_BANKS-1:0][PIX_W-1:0] rd_data;
  dpd_chwin_t [NUM_CH-1:0]         win;
  logic [NUM_CH-1:0]               flags;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      threshold_q  <= THRESHOLD_RST;
      line_width_q <= LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WINDOW_MODE: mode_q       <= pwdata[0];
        REG_THRESHOLD:   threshold_q  <= pwdata[CH_W-1:0];
        REG_LINE_WIDTH:  line_width_q <= pwdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_MODE: prdata = PDATA_W'(mode_q);
      REG_THRESHOLD:   prdata = PDATA_W'(threshold_q);
      REG_LINE_WIDTH:  prdata = PDATA_W'(line_width_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (line_width_q < LW_W'(MIN_WIDTH)) begin
      eff_w = LW_W'(MIN_WIDTH);
    end else if (32'(line_width_q) > MAX_WIDTH) begin
      eff_w = LW_W'(MAX_WIDTH);
    end else begin
      eff_w = line_width_q;
    end
  end

  // handshake and position counters
  assign adv        = !stall;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;
  assign col_inc    = (COL_W+1)'(col_q) + 1'b1;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (last_pixel_i) begin
      row_d = '0;
      col_d = '0;
    end else if (32'(col_inc) >= 32'(eff_w)) begin
      col_d = '0;
      row_d = (32'(row_q) + 1 >= MAX_HEIGHT) ? '0 : ROW_W'(row_q + 1'b1);
    end else begin
      col_d = COL_W'(col_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: pixel and position beside the line-store read
  always_ff @(posedge clk_i) begin
    if (acc) begin
      px1_q  <= pixel_i;
      row1_q <= row_q;
      col1_q <= col_q;
    end
  end

  // stage 2: window centre position
  always_comb begin
    pos2_d.elig  = mode_q ? (row1_q >= ROW_W'(4) && col1_q >= COL_W'(4))
                          : (row1_q >= ROW_W'(2) && col1_q >= COL_W'(2));
    pos2_d.row   = row1_q - (mode_q ? ROW_W'(2) : ROW_W'(1));
    pos2_d.col   = col1_q - (mode_q ? COL_W'(2) : COL_W'(1));
    pos2_d.index = '0;
  end

  // stage 3: linear index
  always_comb begin
    prod         = pos2_q.row * eff_w;
    pos3_d       = pos2_q;
    pos3_d.index = IDX_W'(prod) + IDX_W'(pos2_q.col);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos2_q <= pos2_d;
      pos3_q <= pos3_d;
      pos4_q <= pos3_q;
    end
  end

  dpd_line_store u_line_store (
    .clk_i     (clk_i),
    .acc_i     (acc),
    .wr_slot_i (row_q[SLOT_W-1:0]),
    .col_i     (col_q),
    .pixel_i   (pixel_i),
    .rd_data_o (rd_data)
  );

  dpd_window u_window (
    .clk_i      (clk_i),
    .shift_i    (v1_q && adv),
    .pixel_i    (px1_q),
    .row_slot_i (row1_q[SLOT_W-1:0]),
    .rd_data_i  (rd_data),
    .win_o      (win)
  );

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    dpd_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (adv),
      .mode_i      (mode_q),
      .threshold_i (threshold_q),
      .win_i       (win[ch]),
      .flag_o      (flags[ch])
    );
  end

  dpd_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (v4_q),
    .pos_i          (pos4_q),
    .flags_i        (flags),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .defect_row_o   (defect_row_o),
    .defect_col_o   (defect_col_o),
    .defect_index_o (defect_index_o),
    .stall_o        (stall)
  );

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  a_result_from_judged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v4_q && pos4_q.elig))
    else $error("result from a centre that was not judged");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && adv |=> v2_q)
    else $error("word lost between read and window stage");

endmodule

`default_nettype wire
